### rtl/cmpc_pkg.sv
// shared types and constants for the color math pixel combiner
// no dependencies; used by every module under rtl
package cmpc_pkg;

    localparam int COLOR_W   = 15;
    localparam int CHAN_W    = 5;
    localparam int NUM_CHAN  = 3;
    localparam int SRC_W     = 3;
    localparam int NUM_SRC   = 7;
    localparam int CFG_IDX_W = 3;

    localparam logic [SRC_W-1:0] SRC_NO_MATH  = 3'd5;
    localparam logic [SRC_W-1:0] SRC_BACKDROP = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_COLOR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_SUB_SCREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBTRACT_MODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALVE_ENABLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_ENABLE     = 3'd4;

    typedef struct packed {
        logic [COLOR_W-1:0] fixed_color;
        logic               use_sub_screen;
        logic               subtract_mode;
        logic               halve_enable;
        logic [NUM_SRC-1:0] source_enable_mask;
    } t_cfg;

endpackage

### rtl/color_math_pixel_combiner.sv
// top level of the color math pixel combiner: input register, color math, result register
// depends on cmpc_pkg, cmpc_cfg_regs and cmpc_blend
//
//  channel   direction  handshake              payload
//  input     in         i_valid / o_stall      i_main_color .. i_swap_layers
//  result    out        o_valid / i_stall      o_pixel_color
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one item per cycle sustained while the result side is not stalled; each item passes
// through the input register, then the color math, then the result register.
// synchronous active-low reset clears the valid flags and the config registers.
// a stall on the result side holds the result register, then the input register;
// o_stall rises only when both registers hold an item and the output is stalled.
// config writes are always ready and take effect on the next cycle.
module color_math_pixel_combiner (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [cmpc_pkg::COLOR_W-1:0]   i_main_color,
    input  logic [cmpc_pkg::SRC_W-1:0]     i_main_source,
    input  logic [cmpc_pkg::COLOR_W-1:0]   i_sub_color,
    input  logic [cmpc_pkg::SRC_W-1:0]     i_sub_source,
    input  logic                           i_window_main,
    input  logic                           i_window_sub,
    input  logic                           i_swap_layers,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [cmpc_pkg::COLOR_W-1:0]   o_pixel_color,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cmpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cmpc_pkg::COLOR_W-1:0]   i_cfg_data
);

    cmpc_pkg::t_cfg cfg;

    logic                         r_in_valid;
    logic [cmpc_pkg::COLOR_W-1:0] r_main_color;
    logic [cmpc_pkg::SRC_W-1:0]   r_main_source;
    logic [cmpc_pkg::COLOR_W-1:0] r_sub_color;
    logic [cmpc_pkg::SRC_W-1:0]   r_sub_source;
    logic                         r_window_main;
    logic                         r_window_sub;
    logic                         r_swap_layers;
    logic                         r_out_valid;
    logic [cmpc_pkg::COLOR_W-1:0] r_pixel_color;
    logic [cmpc_pkg::COLOR_W-1:0] n_pixel_color;
    logic                         out_advance;
    logic                         in_advance;

    assign o_cfg_ready = 1'b1;

    cmpc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    cmpc_blend u_blend (
        .i_cfg         (cfg),
        .i_main_color  (r_main_color),
        .i_main_source (r_main_source),
        .i_sub_color   (r_sub_color),
        .i_sub_source  (r_sub_source),
        .i_window_main (r_window_main),
        .i_window_sub  (r_window_sub),
        .i_swap_layers (r_swap_layers),
        .o_pixel_color (n_pixel_color)
    );

    assign out_advance = !r_out_valid || !i_stall;
    assign in_advance  = !r_in_valid || out_advance;
    assign o_stall     = !in_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_advance) begin
                r_in_valid <= i_valid;
            end
            if (out_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_advance && i_valid) begin
            r_main_color  <= i_main_color;
            r_main_source <= i_main_source;
            r_sub_color   <= i_sub_color;
            r_sub_source  <= i_sub_source;
            r_window_main <= i_window_main;
            r_window_sub  <= i_window_sub;
            r_swap_layers <= i_swap_layers;
        end
        if (out_advance && r_in_valid) begin
            r_pixel_color <= n_pixel_color;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_color = r_pixel_color;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled without a full pipe and a stalled output");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_advance) |=> r_in_valid)
        else $error("item in input register lost while output stalled");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_pixel_color)))
        else $error("stalled result dropped or changed");

endmodule

### rtl/cmpc_cfg_regs.sv
// configuration register bank of the color math pixel combiner
// depends on cmpc_pkg for register indexes and the t_cfg struct
module cmpc_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [cmpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cmpc_pkg::COLOR_W-1:0]   i_cfg_data,
    output cmpc_pkg::t_cfg                 o_cfg
);

    cmpc_pkg::t_cfg r_cfg;
    cmpc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cmpc_pkg::CFG_FIXED_COLOR:    n_cfg.fixed_color    = i_cfg_data;
                cmpc_pkg::CFG_USE_SUB_SCREEN: n_cfg.use_sub_screen = i_cfg_data[0];
                cmpc_pkg::CFG_SUBTRACT_MODE:  n_cfg.subtract_mode  = i_cfg_data[0];
                cmpc_pkg::CFG_HALVE_ENABLE:   n_cfg.halve_enable   = i_cfg_data[0];
                cmpc_pkg::CFG_SRC_ENABLE: begin
                    n_cfg.source_enable_mask = i_cfg_data[cmpc_pkg::NUM_SRC-1:0];
                end
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/cmpc_blend.sv
// per-pixel color math: role swap, operand select, window gating and
// per-channel saturating add or clamped subtract with optional halving; uses cmpc_pkg
module cmpc_blend (
    input  cmpc_pkg::t_cfg               i_cfg,
    input  logic [cmpc_pkg::COLOR_W-1:0] i_main_color,
    input  logic [cmpc_pkg::SRC_W-1:0]   i_main_source,
    input  logic [cmpc_pkg::COLOR_W-1:0] i_sub_color,
    input  logic [cmpc_pkg::SRC_W-1:0]   i_sub_source,
    input  logic                         i_window_main,
    input  logic                         i_window_sub,
    input  logic                         i_swap_layers,
    output logic [cmpc_pkg::COLOR_W-1:0] o_pixel_color
);

    localparam int CW = cmpc_pkg::CHAN_W;

    logic [cmpc_pkg::COLOR_W-1:0] mcol;
    logic [cmpc_pkg::COLOR_W-1:0] ocol;
    logic [cmpc_pkg::SRC_W-1:0]   msrc;
    logic [cmpc_pkg::SRC_W-1:0]   osrc;
    logic [cmpc_pkg::NUM_SRC:0]   mask_ext;
    logic                         math_en;
    logic                         half;
    logic [cmpc_pkg::COLOR_W-1:0] blended;

    always_comb begin
        mcol = i_swap_layers ? i_sub_color   : i_main_color;
        msrc = i_swap_layers ? i_sub_source  : i_main_source;
        ocol = i_swap_layers ? i_main_color  : i_sub_color;
        osrc = i_swap_layers ? i_main_source : i_sub_source;
        if (!i_cfg.use_sub_screen) begin
            ocol = i_cfg.fixed_color;
            osrc = cmpc_pkg::SRC_BACKDROP;
        end
        if (!i_window_main) begin
            mcol = '0;
        end
        // top bit stands for code 7, which has no enable bit
        mask_ext = {1'b0, i_cfg.source_enable_mask};
        math_en = i_window_sub && (msrc != cmpc_pkg::SRC_NO_MATH) && mask_ext[msrc];
        half = i_cfg.halve_enable && i_window_main
               && (!i_cfg.use_sub_screen || osrc != cmpc_pkg::SRC_BACKDROP);
    end

    // three independent channels
    for (genvar g = 0; g < cmpc_pkg::NUM_CHAN; g++) begin : g_chan
        logic [CW-1:0] a;
        logic [CW-1:0] b;
        logic [CW:0]   sum;
        logic [CW:0]   diff;
        logic [CW-1:0] r;

        always_comb begin
            a    = mcol[g*CW +: CW];
            b    = ocol[g*CW +: CW];
            sum  = {1'b0, a} + {1'b0, b};
            diff = {1'b0, a} - {1'b0, b};
            if (!i_cfg.subtract_mode) begin
                if (half) begin
                    r = sum[CW:1];
                end else begin
                    r = sum[CW] ? {CW{1'b1}} : sum[CW-1:0];
                end
            end else begin
                // borrow out means clamp at zero
                r = diff[CW] ? '0 : diff[CW-1:0];
                if (half) begin
                    r = {1'b0, r[CW-1:1]};
                end
            end
        end

        assign blended[g*CW +: CW] = r;
    end

    always_comb begin
        if (!i_window_main && !i_window_sub) begin
            o_pixel_color = '0;
        end else if (math_en) begin
            o_pixel_color = blended;
        end else begin
            o_pixel_color = mcol;
        end
    end

endmodule

### test/cmpc_pixel_checker.sv
// checker for the color math pixel combiner: watches the input, result and config channels,
// predicts each pixel color and compares it with the results in order
// depends on cmpc_pkg
`timescale 1ns / 1ps

module cmpc_pixel_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [cmpc_pkg::COLOR_W-1:0]   i_main_color,
    input  logic [cmpc_pkg::SRC_W-1:0]     i_main_source,
    input  logic [cmpc_pkg::COLOR_W-1:0]   i_sub_color,
    input  logic [cmpc_pkg::SRC_W-1:0]     i_sub_source,
    input  logic                           i_window_main,
    input  logic                           i_window_sub,
    input  logic                           i_swap_layers,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [cmpc_pkg::COLOR_W-1:0]   i_pixel_color,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [cmpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cmpc_pkg::COLOR_W-1:0]   i_cfg_data,
    output int                             o_mismatches,
    output int                             o_outstanding
);

    cmpc_pkg::t_cfg               regs_shadow;
    logic [cmpc_pkg::COLOR_W-1:0] expected_colors[$];

    function automatic logic [cmpc_pkg::COLOR_W-1:0] combine_pixel(
        input cmpc_pkg::t_cfg               cfg,
        input logic [cmpc_pkg::COLOR_W-1:0] main_c,
        input logic [cmpc_pkg::SRC_W-1:0]   main_s,
        input logic [cmpc_pkg::COLOR_W-1:0] sub_c,
        input logic [cmpc_pkg::SRC_W-1:0]   sub_s,
        input logic                         win_main,
        input logic                         win_sub,
        input logic                         swap
    );
        logic [cmpc_pkg::COLOR_W-1:0] role_c;
        logic [cmpc_pkg::COLOR_W-1:0] oper_c;
        logic [cmpc_pkg::SRC_W-1:0]   role_s;
        logic [cmpc_pkg::SRC_W-1:0]   oper_s;
        logic [cmpc_pkg::COLOR_W-1:0] res;
        logic                         src_en;
        logic                         halve;
        int                           a;
        int                           b;
        int                           r;
        role_c = swap ? sub_c : main_c;
        role_s = swap ? sub_s : main_s;
        oper_c = swap ? main_c : sub_c;
        oper_s = swap ? main_s : sub_s;
        if (!cfg.use_sub_screen) begin
            // fixed operand behaves like the backdrop
            oper_c = cfg.fixed_color;
            oper_s = cmpc_pkg::SRC_BACKDROP;
        end
        if (!win_main && !win_sub) begin
            return '0;
        end
        if (!win_main) begin
            role_c = '0;
        end
        src_en = (role_s < cmpc_pkg::NUM_SRC) ? cfg.source_enable_mask[role_s] : 1'b0;
        if (!win_sub || role_s == cmpc_pkg::SRC_NO_MATH || !src_en) begin
            return role_c;
        end
        halve = cfg.halve_enable && win_main &&
                (!cfg.use_sub_screen || oper_s != cmpc_pkg::SRC_BACKDROP);
        for (int ch = 0; ch < cmpc_pkg::NUM_CHAN; ch++) begin
            a = role_c[ch*cmpc_pkg::CHAN_W +: cmpc_pkg::CHAN_W];
            b = oper_c[ch*cmpc_pkg::CHAN_W +: cmpc_pkg::CHAN_W];
            if (!cfg.subtract_mode) begin
                if (halve) r = (a + b) / 2;
                else r = (a + b > 31) ? 31 : a + b;
            end else begin
                r = (a > b) ? a - b : 0;
                if (halve) r = r / 2;
            end
            res[ch*cmpc_pkg::CHAN_W +: cmpc_pkg::CHAN_W] = r[cmpc_pkg::CHAN_W-1:0];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs_shadow = '0;
            expected_colors.delete();
            o_mismatches <= 0;
            o_outstanding <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                unique case (i_cfg_index)
                    cmpc_pkg::CFG_FIXED_COLOR:
                        regs_shadow.fixed_color = i_cfg_data;
                    cmpc_pkg::CFG_USE_SUB_SCREEN:
                        regs_shadow.use_sub_screen = i_cfg_data[0];
                    cmpc_pkg::CFG_SUBTRACT_MODE:
                        regs_shadow.subtract_mode = i_cfg_data[0];
                    cmpc_pkg::CFG_HALVE_ENABLE:
                        regs_shadow.halve_enable = i_cfg_data[0];
                    cmpc_pkg::CFG_SRC_ENABLE:
                        regs_shadow.source_enable_mask = i_cfg_data[cmpc_pkg::NUM_SRC-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expected_colors.push_back(combine_pixel(regs_shadow, i_main_color,
                    i_main_source, i_sub_color, i_sub_source, i_window_main,
                    i_window_sub, i_swap_layers));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_colors.size() == 0) begin
                    $display("%0t: unexpected pixel_color, expected none, actual %h",
                             $time, i_pixel_color);
                    o_mismatches <= o_mismatches + 1;
                end else if (expected_colors[0] !== i_pixel_color) begin
                    $display("%0t: pixel_color mismatch, expected %h, actual %h",
                             $time, expected_colors[0], i_pixel_color);
                    o_mismatches <= o_mismatches + 1;
                    void'(expected_colors.pop_front());
                end else begin
                    void'(expected_colors.pop_front());
                end
            end
            o_outstanding <= expected_colors.size();
        end
    end

endmodule

### test/tb_top.sv
// top of the color math pixel combiner testbench: clock, reset, pixel and config stimulus,
// random stalls, watchdog and verdict; checking is done in cmpc_pixel_checker
// depends on cmpc_pkg, color_math_pixel_combiner and cmpc_pixel_checker
`timescale 1ns / 1ps

module tb_top;

    localparam int IDLE_LIMIT   = 2000;
    localparam int ITEMS_PER_SEG = 110;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_stall;
    logic [cmpc_pkg::COLOR_W-1:0]   i_main_color = '0;
    logic [cmpc_pkg::SRC_W-1:0]     i_main_source = '0;
    logic [cmpc_pkg::COLOR_W-1:0]   i_sub_color = '0;
    logic [cmpc_pkg::SRC_W-1:0]     i_sub_source = '0;
    logic                           i_window_main = 1'b0;
    logic                           i_window_sub = 1'b0;
    logic                           i_swap_layers = 1'b0;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    logic [cmpc_pkg::COLOR_W-1:0]   o_pixel_color;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [cmpc_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [cmpc_pkg::COLOR_W-1:0]   i_cfg_data = '0;

    int mismatches;
    int outstanding;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    color_math_pixel_combiner dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_main_color  (i_main_color),
        .i_main_source (i_main_source),
        .i_sub_color   (i_sub_color),
        .i_sub_source  (i_sub_source),
        .i_window_main (i_window_main),
        .i_window_sub  (i_window_sub),
        .i_swap_layers (i_swap_layers),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_color (o_pixel_color),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    cmpc_pixel_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_main_color  (i_main_color),
        .i_main_source (i_main_source),
        .i_sub_color   (i_sub_color),
        .i_sub_source  (i_sub_source),
        .i_window_main (i_window_main),
        .i_window_sub  (i_window_sub),
        .i_swap_layers (i_swap_layers),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_pixel_color (o_pixel_color),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always @(posedge i_clk) begin
        i_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // watchdog: cycles in which no channel moves anything
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic logic [cmpc_pkg::COLOR_W-1:0] pick_color();
        logic [cmpc_pkg::COLOR_W-1:0] c;
        case ($urandom_range(3))
            0: c = cmpc_pkg::COLOR_W'($urandom_range(32'h7fff));
            1: begin
                for (int ch = 0; ch < cmpc_pkg::NUM_CHAN; ch++)
                    c[ch*cmpc_pkg::CHAN_W +: cmpc_pkg::CHAN_W] =
                        $urandom_range(1) ? 5'd31 : 5'd0;
            end
            2: begin
                // channels close to the saturation and clamp points
                for (int ch = 0; ch < cmpc_pkg::NUM_CHAN; ch++)
                    c[ch*cmpc_pkg::CHAN_W +: cmpc_pkg::CHAN_W] = $urandom_range(1) ?
                        5'(31 - $urandom_range(2)) : 5'($urandom_range(2));
            end
            default: c = $urandom_range(1) ? '1 : '0;
        endcase
        return c;
    endfunction

    task automatic send_pixel(
        input logic [cmpc_pkg::COLOR_W-1:0] main_c,
        input logic [cmpc_pkg::SRC_W-1:0]   main_s,
        input logic [cmpc_pkg::COLOR_W-1:0] sub_c,
        input logic [cmpc_pkg::SRC_W-1:0]   sub_s,
        input logic                         win_main,
        input logic                         win_sub,
        input logic                         swap
    );
        while ((send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_main_color  <= main_c;
        i_main_source <= main_s;
        i_sub_color   <= sub_c;
        i_sub_source  <= sub_s;
        i_window_main <= win_main;
        i_window_sub  <= win_sub;
        i_swap_layers <= swap;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_random_pixel();
        send_pixel(pick_color(), cmpc_pkg::SRC_W'($urandom_range(7)), pick_color(),
                   cmpc_pkg::SRC_W'($urandom_range(7)), $urandom_range(99) < 80,
                   $urandom_range(99) < 80, 1'($urandom_range(1)));
    endtask

    // stop sending and wait until every predicted pixel has come out
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(
        input logic [cmpc_pkg::CFG_IDX_W-1:0] idx,
        input logic [cmpc_pkg::COLOR_W-1:0]   data
    );
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic program_regs(
        input logic [cmpc_pkg::COLOR_W-1:0] fixed,
        input logic                         use_sub,
        input logic                         sub_mode,
        input logic                         halve,
        input logic [cmpc_pkg::NUM_SRC-1:0] mask
    );
        drain();
        write_reg(cmpc_pkg::CFG_FIXED_COLOR, fixed);
        write_reg(cmpc_pkg::CFG_USE_SUB_SCREEN, cmpc_pkg::COLOR_W'(use_sub));
        write_reg(cmpc_pkg::CFG_SUBTRACT_MODE, cmpc_pkg::COLOR_W'(sub_mode));
        write_reg(cmpc_pkg::CFG_HALVE_ENABLE, cmpc_pkg::COLOR_W'(halve));
        write_reg(cmpc_pkg::CFG_SRC_ENABLE, cmpc_pkg::COLOR_W'(mask));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int send_idle_by_phase[4];
        int stall_by_phase[4];
        send_idle_by_phase = '{0, 59, 0, 37};
        stall_by_phase     = '{0, 0, 59, 37};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // add screens, no halving, all sources enabled
        program_regs(15'h0000, 1'b1, 1'b0, 1'b0, 7'h7f);
        send_pixel(15'h7fff, 3'd0, 15'h7fff, 3'd1, 1'b1, 1'b1, 1'b0);
        send_pixel(15'h0000, 3'd1, 15'h0000, 3'd2, 1'b1, 1'b1, 1'b0);
        send_pixel(15'h001f, 3'd2, 15'h03e0, 3'd3, 1'b1, 1'b1, 1'b0);
        send_pixel(15'h7fff, 3'd3, 15'h7fff, 3'd4, 1'b0, 1'b0, 1'b0);
        send_pixel(15'h7fff, 3'd4, 15'h1234, 3'd0, 1'b0, 1'b1, 1'b0);
        send_pixel(15'h4321, 3'd0, 15'h1111, 3'd1, 1'b1, 1'b0, 1'b0);
        send_pixel(15'h7fff, 3'd5, 15'h0421, 3'd0, 1'b1, 1'b1, 1'b0);
        send_pixel(15'h7fff, 3'd7, 15'h0421, 3'd0, 1'b1, 1'b1, 1'b0);
        send_pixel(15'h0421, 3'd7, 15'h7fff, 3'd0, 1'b1, 1'b1, 1'b1);
        send_pixel(15'h1234, 3'd6, 15'h5678, 3'd6, 1'b1, 1'b1, 1'b0);

        // subtract the fixed color with halving
        program_regs(15'h4210, 1'b0, 1'b1, 1'b1, 7'h7f);
        send_pixel(15'h7fff, 3'd0, 15'h0000, 3'd6, 1'b1, 1'b1, 1'b0);
        send_pixel(15'h0000, 3'd1, 15'h7fff, 3'd6, 1'b1, 1'b1, 1'b0);
        send_pixel(15'h7fff, 3'd2, 15'h7fff, 3'd3, 1'b0, 1'b1, 1'b0);
        send_pixel(15'h1234, 3'd5, 15'h7c1f, 3'd3, 1'b1, 1'b1, 1'b1);

        // subtract the other screen with halving, blocked where the operand is the backdrop
        program_regs(15'h7fff, 1'b1, 1'b1, 1'b1, 7'h7f);
        send_pixel(15'h7fff, 3'd0, 15'h0c63, 3'd6, 1'b1, 1'b1, 1'b0);
        send_pixel(15'h7fff, 3'd0, 15'h0c63, 3'd3, 1'b1, 1'b1, 1'b0);
        send_pixel(15'h7fff, 3'd4, 15'h0c63, 3'd7, 1'b1, 1'b1, 1'b0);
        send_pixel(15'h0c63, 3'd2, 15'h7fff, 3'd6, 1'b1, 1'b1, 1'b1);

        // add with halving, only even sources enabled
        program_regs(15'h7fff, 1'b1, 1'b0, 1'b1, 7'h55);
        send_pixel(15'h7fff, 3'd0, 15'h7fff, 3'd1, 1'b1, 1'b1, 1'b0);
        send_pixel(15'h0001, 3'd0, 15'h0000, 3'd1, 1'b1, 1'b1, 1'b0);
        send_pixel(15'h7fff, 3'd1, 15'h7fff, 3'd2, 1'b1, 1'b1, 1'b0);
        send_pixel(15'h7fff, 3'd6, 15'h0421, 3'd6, 1'b1, 1'b1, 1'b0);
        send_pixel(15'h0421, 3'd4, 15'h7fff, 3'd6, 1'b0, 1'b1, 1'b0);

        for (int phase = 0; phase < 4; phase++) begin
            for (int seg = 0; seg < 3; seg++) begin
                case (seg)
                    0: program_regs(15'h7fff, 1'($urandom_range(1)), 1'($urandom_range(1)),
                                    1'($urandom_range(1)), 7'h7f);
                    1: program_regs(pick_color(), 1'($urandom_range(1)),
                                    1'($urandom_range(1)), 1'($urandom_range(1)),
                                    cmpc_pkg::NUM_SRC'($urandom_range(127)));
                    default: program_regs(15'h0000, 1'($urandom_range(1)),
                                          1'($urandom_range(1)), 1'($urandom_range(1)),
                                          cmpc_pkg::NUM_SRC'($urandom_range(127)));
                endcase
                send_idle_pct = send_idle_by_phase[phase];
                stall_pct     = stall_by_phase[phase];
                repeat (ITEMS_PER_SEG) send_random_pixel();
            end
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/cmpc_pkg.sv
rtl/cmpc_cfg_regs.sv
rtl/cmpc_blend.sv
rtl/color_math_pixel_combiner.sv
test/cmpc_pixel_checker.sv
test/tb_top.sv
